FILE: rtl/y2n_pkg.sv
// Shared constants, types and codes for the YUY2 to NV12 converter.
package y2n_pkg;

  localparam int unsigned MAX_PAIRS_PER_LINE = 2048;
  localparam int unsigned COL_W = $clog2(MAX_PAIRS_PER_LINE);
  localparam int unsigned ADDR_W = COL_W + 1;
  localparam int unsigned STORE_DEPTH = 2 * MAX_PAIRS_PER_LINE;
  localparam int unsigned PIX_W = 8;
  localparam int unsigned SUM_W = PIX_W + 2;
  localparam int unsigned STORE_W = 2 * PIX_W;
  localparam int unsigned PPL_W = 12;
  localparam int unsigned CMP_W = (COL_W + 1 > PPL_W) ? COL_W + 1 : PPL_W;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_MODE_ADDR = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PPL_ADDR = 3'd4;
  localparam logic [PPL_W-1:0] PPL_RESET = 12'd960;

  typedef enum logic [1:0] {
    OpStore = 2'd0,
    OpAvg   = 2'd1,
    OpUpper = 2'd2,
    OpLower = 2'd3
  } op_e;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [ADDR_W-1:0]  addr;
    logic [STORE_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    op_e  op;
    logic eol;
  } item_t;

endpackage

FILE: rtl/y2n_ram.sv
// Generic single-port synchronous RAM with registered, enabled read.
module y2n_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/y2n_addr.sv
// Column and row tracking, line-store address generation and access request.
module y2n_addr (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          frame_start_i,
  input  logic                          interlaced_i,
  input  logic [y2n_pkg::PPL_W-1:0]     pairs_per_line_i,
  input  logic [y2n_pkg::PIX_W-1:0]     chroma_blue_i,
  input  logic [y2n_pkg::PIX_W-1:0]     chroma_red_i,
  output y2n_pkg::mem_req_t             mem_req_o,
  output y2n_pkg::item_t                item_o
);

  logic [y2n_pkg::COL_W-1:0] column_q, column_d;
  logic [1:0]                phase_q, phase_d;
  logic [y2n_pkg::COL_W-1:0] col_base;
  logic [1:0]                phase;
  logic [y2n_pkg::CMP_W-1:0] ppl_ext;
  logic [y2n_pkg::CMP_W-1:0] len;
  logic [y2n_pkg::CMP_W-1:0] last;
  logic [y2n_pkg::CMP_W-1:0] col_ext;
  logic [y2n_pkg::CMP_W-1:0] col_clip;
  logic [y2n_pkg::COL_W-1:0] col;
  logic                      eol;
  logic                      slot;
  y2n_pkg::op_e              op;

  always_comb begin
    col_base = frame_start_i ? '0 : column_q;
    phase    = frame_start_i ? 2'd0 : phase_q;
    ppl_ext  = y2n_pkg::CMP_W'(pairs_per_line_i);
    if (ppl_ext == '0) begin
      len = y2n_pkg::CMP_W'(1);
    end else if (ppl_ext > y2n_pkg::CMP_W'(y2n_pkg::MAX_PAIRS_PER_LINE)) begin
      len = y2n_pkg::CMP_W'(y2n_pkg::MAX_PAIRS_PER_LINE);
    end else begin
      len = ppl_ext;
    end
    last     = len - y2n_pkg::CMP_W'(1);
    col_ext  = y2n_pkg::CMP_W'(col_base);
    col_clip = (col_ext >= len) ? last : col_ext;
    col      = col_clip[y2n_pkg::COL_W-1:0];
    eol      = (col_clip == last);
    slot     = phase[0];

    if (!interlaced_i) begin
      op = slot ? y2n_pkg::OpAvg : y2n_pkg::OpStore;
    end else if (phase[1]) begin
      op = slot ? y2n_pkg::OpLower : y2n_pkg::OpUpper;
    end else begin
      op = y2n_pkg::OpStore;
    end

    mem_req_o.we    = accept_i && (op == y2n_pkg::OpStore);
    mem_req_o.re    = accept_i && (op != y2n_pkg::OpStore);
    mem_req_o.addr  = {slot & interlaced_i, col};
    mem_req_o.wdata = {chroma_red_i, chroma_blue_i};
    item_o.op       = op;
    item_o.eol      = eol;

    column_d = column_q;
    phase_d  = phase_q;
    if (accept_i) begin
      if (eol) begin
        column_d = '0;
        phase_d  = phase + 2'd1;
      end else begin
        column_d = col + y2n_pkg::COL_W'(1);
        phase_d  = phase;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      phase_q  <= 2'd0;
    end else begin
      column_q <= column_d;
      phase_q  <= phase_d;
    end
  end

endmodule

FILE: rtl/y2n_filter.sv
// Line-store read stage, vertical chroma filter and output register.
module y2n_filter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  y2n_pkg::item_t              item_i,
  input  logic [y2n_pkg::PIX_W-1:0]   luma_first_i,
  input  logic [y2n_pkg::PIX_W-1:0]   luma_second_i,
  input  logic [y2n_pkg::PIX_W-1:0]   chroma_blue_i,
  input  logic [y2n_pkg::PIX_W-1:0]   chroma_red_i,
  input  logic [y2n_pkg::STORE_W-1:0] rdata_i,
  output logic                        ready_o,
  output logic                        stall_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [y2n_pkg::PIX_W-1:0]   luma_out_first_o,
  output logic [y2n_pkg::PIX_W-1:0]   luma_out_second_o,
  output logic                        chroma_valid_o,
  output logic [y2n_pkg::PIX_W-1:0]   chroma_blue_out_o,
  output logic [y2n_pkg::PIX_W-1:0]   chroma_red_out_o,
  output logic                        end_of_line_o
);

  function automatic logic [y2n_pkg::PIX_W-1:0] blend(
    input y2n_pkg::op_e              op,
    input logic [y2n_pkg::PIX_W-1:0] upper,
    input logic [y2n_pkg::PIX_W-1:0] cur
  );
    logic [y2n_pkg::SUM_W-1:0] u;
    logic [y2n_pkg::SUM_W-1:0] c;
    logic [y2n_pkg::SUM_W-1:0] s;
    logic [y2n_pkg::PIX_W-1:0] r;
    u = y2n_pkg::SUM_W'(upper);
    c = y2n_pkg::SUM_W'(cur);
    s = '0;
    r = '0;
    case (op)
      y2n_pkg::OpAvg: begin
        s = u + c + y2n_pkg::SUM_W'(1);
        r = s[y2n_pkg::PIX_W:1];
      end
      y2n_pkg::OpUpper: begin
        s = (u << 1) + u + c + y2n_pkg::SUM_W'(2);
        r = s[y2n_pkg::PIX_W+1:2];
      end
      y2n_pkg::OpLower: begin
        s = u + (c << 1) + c + y2n_pkg::SUM_W'(2);
        r = s[y2n_pkg::PIX_W+1:2];
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  logic                      s1_valid_q;
  y2n_pkg::item_t            s1_item_q;
  logic [y2n_pkg::PIX_W-1:0] s1_ya_q, s1_yb_q, s1_cb_q, s1_cr_q;
  logic                      advance;
  logic                      out_valid_q;
  logic [y2n_pkg::PIX_W-1:0] ya_q, yb_q, cb_out_q, cr_out_q;
  logic                      cv_q, eol_q;
  logic [y2n_pkg::PIX_W-1:0] cb_d, cr_d;
  logic                      cv_d;

  assign advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign ready_o = !s1_valid_q || advance;
  assign stall_o = s1_valid_q && !advance;

  always_comb begin
    cv_d = (s1_item_q.op != y2n_pkg::OpStore);
    cb_d = blend(s1_item_q.op, rdata_i[y2n_pkg::PIX_W-1:0], s1_cb_q);
    cr_d = blend(s1_item_q.op, rdata_i[y2n_pkg::STORE_W-1:y2n_pkg::PIX_W], s1_cr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_item_q <= item_i;
      s1_ya_q   <= luma_first_i;
      s1_yb_q   <= luma_second_i;
      s1_cb_q   <= chroma_blue_i;
      s1_cr_q   <= chroma_red_i;
    end
    if (advance) begin
      ya_q     <= s1_ya_q;
      yb_q     <= s1_yb_q;
      cv_q     <= cv_d;
      cb_out_q <= cb_d;
      cr_out_q <= cr_d;
      eol_q    <= s1_item_q.eol;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign luma_out_first_o  = ya_q;
  assign luma_out_second_o = yb_q;
  assign chroma_valid_o    = cv_q;
  assign chroma_blue_out_o = cb_out_q;
  assign chroma_red_out_o  = cr_out_q;
  assign end_of_line_o     = eol_q;

endmodule

FILE: rtl/yuy2_to_nv12_converter.sv
// Top level of the YUY2 to NV12 converter with its register port.
// The block takes one YUY2 word per clock while in_ready_o is high and returns
// one word per input word through the read stage and then the output register.
// Sustained throughput is one word per cycle when neither side stalls, set by
// the single-port chroma line store of 4096 entries by 16 bits, which each word
// uses exactly once: rows that keep chroma write it and rows that emit chroma
// read it. The store needs no clearing after reset. The user must write the two
// configuration registers only while no words are in flight; not enforced here.
module yuy2_to_nv12_converter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [y2n_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [y2n_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [y2n_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [y2n_pkg::PIX_W-1:0]       luma_first_i,
  input  logic [y2n_pkg::PIX_W-1:0]       chroma_blue_i,
  input  logic [y2n_pkg::PIX_W-1:0]       luma_second_i,
  input  logic [y2n_pkg::PIX_W-1:0]       chroma_red_i,
  input  logic                            frame_start_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [y2n_pkg::PIX_W-1:0]       luma_out_first_o,
  output logic [y2n_pkg::PIX_W-1:0]       luma_out_second_o,
  output logic                            chroma_valid_o,
  output logic [y2n_pkg::PIX_W-1:0]       chroma_blue_out_o,
  output logic [y2n_pkg::PIX_W-1:0]       chroma_red_out_o,
  output logic                            end_of_line_o
);

  logic                          mode_q;
  logic [y2n_pkg::PPL_W-1:0]     ppl_q;
  logic                          cfg_write;
  logic                          accept;
  logic                          stall;
  y2n_pkg::mem_req_t             mem_req;
  y2n_pkg::item_t                item;
  logic [y2n_pkg::STORE_W-1:0]   rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign accept    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      ppl_q  <= y2n_pkg::PPL_RESET;
    end else if (cfg_write) begin
      case (paddr)
        y2n_pkg::REG_MODE_ADDR: mode_q <= pwdata[0];
        y2n_pkg::REG_PPL_ADDR:  ppl_q  <= pwdata[y2n_pkg::PPL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      y2n_pkg::REG_MODE_ADDR: prdata = y2n_pkg::CFG_DATA_W'(mode_q);
      y2n_pkg::REG_PPL_ADDR:  prdata = y2n_pkg::CFG_DATA_W'(ppl_q);
      default:                prdata = '0;
    endcase
  end

  y2n_addr u_addr (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .frame_start_i    (frame_start_i),
    .interlaced_i     (mode_q),
    .pairs_per_line_i (ppl_q),
    .chroma_blue_i    (chroma_blue_i),
    .chroma_red_i     (chroma_red_i),
    .mem_req_o        (mem_req),
    .item_o           (item)
  );

  y2n_ram #(
    .WIDTH (y2n_pkg::STORE_W),
    .DEPTH (y2n_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

  y2n_filter u_filter (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .item_i            (item),
    .luma_first_i      (luma_first_i),
    .luma_second_i     (luma_second_i),
    .chroma_blue_i     (chroma_blue_i),
    .chroma_red_i      (chroma_red_i),
    .rdata_i           (rdata),
    .ready_o           (in_ready_o),
    .stall_o           (stall),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .luma_out_first_o  (luma_out_first_o),
    .luma_out_second_o (luma_out_second_o),
    .chroma_valid_o    (chroma_valid_o),
    .chroma_blue_out_o (chroma_blue_out_o),
    .chroma_red_out_o  (chroma_red_out_o),
    .end_of_line_o     (end_of_line_o)
  );

`ifndef SYNTHESIS
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("Line store written and read in the same cycle.");

  a_no_access_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> !mem_req.we && !mem_req.re)
    else $error("Line store accessed while the read stage is stalled.");

  a_frame_start_stores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && frame_start_i |-> mem_req.we && !mem_req.re)
    else $error("First word of a frame did not write the line store.");

  a_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !chroma_valid_o |-> chroma_blue_out_o == '0 && chroma_red_out_o == '0)
    else $error("Chroma output not cleared on a word without chroma.");
`endif

endmodule

FILE: tb/sv/yuy2_to_nv12_converter_tb.sv
// Self-checking testbench for the YUY2 to NV12 converter with randomized handshakes.
module yuy2_to_nv12_converter_tb;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam logic MODE_PROGRESSIVE = 1'b0;
  localparam logic MODE_INTERLACED = 1'b1;

  typedef struct packed {
    logic [y2n_pkg::PIX_W-1:0] luma_first;
    logic [y2n_pkg::PIX_W-1:0] chroma_blue;
    logic [y2n_pkg::PIX_W-1:0] luma_second;
    logic [y2n_pkg::PIX_W-1:0] chroma_red;
    logic                      frame_start;
  } yuy2_word_t;

  typedef struct packed {
    logic [y2n_pkg::PIX_W-1:0] luma_first;
    logic [y2n_pkg::PIX_W-1:0] luma_second;
    logic                      chroma_valid;
    logic [y2n_pkg::PIX_W-1:0] chroma_blue;
    logic [y2n_pkg::PIX_W-1:0] chroma_red;
    logic                      end_of_line;
  } nv12_word_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [y2n_pkg::CFG_ADDR_W-1:0] paddr;
  logic [y2n_pkg::CFG_DATA_W-1:0] pwdata;
  logic [y2n_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [y2n_pkg::PIX_W-1:0]      luma_first_i;
  logic [y2n_pkg::PIX_W-1:0]      chroma_blue_i;
  logic [y2n_pkg::PIX_W-1:0]      luma_second_i;
  logic [y2n_pkg::PIX_W-1:0]      chroma_red_i;
  logic                           frame_start_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [y2n_pkg::PIX_W-1:0]      luma_out_first_o;
  logic [y2n_pkg::PIX_W-1:0]      luma_out_second_o;
  logic                           chroma_valid_o;
  logic [y2n_pkg::PIX_W-1:0]      chroma_blue_out_o;
  logic [y2n_pkg::PIX_W-1:0]      chroma_red_out_o;
  logic                           end_of_line_o;

  logic                        mode_reg;
  logic [y2n_pkg::PPL_W-1:0]   ppl_reg;
  logic [y2n_pkg::STORE_W-1:0] chroma_store [y2n_pkg::STORE_DEPTH];
  bit                          store_written [y2n_pkg::STORE_DEPTH];
  logic [y2n_pkg::COL_W-1:0]   col_pos;
  logic [1:0]                  row_pos;
  nv12_word_t                  nv12_due [$];

  int unsigned mismatch_count = 0;
  int unsigned words_checked = 0;
  int unsigned idle_cycles = 0;
  int unsigned src_gap_max = 8;
  int unsigned sink_stall_max = 8;
  int unsigned sink_hold = 0;

  yuy2_to_nv12_converter dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .luma_first_i      (luma_first_i),
    .chroma_blue_i     (chroma_blue_i),
    .luma_second_i     (luma_second_i),
    .chroma_red_i      (chroma_red_i),
    .frame_start_i     (frame_start_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .luma_out_first_o  (luma_out_first_o),
    .luma_out_second_o (luma_out_second_o),
    .chroma_valid_o    (chroma_valid_o),
    .chroma_blue_out_o (chroma_blue_out_o),
    .chroma_red_out_o  (chroma_red_out_o),
    .end_of_line_o     (end_of_line_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [y2n_pkg::PPL_W-1:0] line_len();
    if (ppl_reg == '0) return y2n_pkg::PPL_W'(1);
    if (ppl_reg > y2n_pkg::MAX_PAIRS_PER_LINE) return y2n_pkg::PPL_W'(y2n_pkg::MAX_PAIRS_PER_LINE);
    return ppl_reg;
  endfunction

  function automatic logic [y2n_pkg::COL_W-1:0] line_col(
    input logic [y2n_pkg::PPL_W-1:0] len
  );
    if (col_pos >= len) return y2n_pkg::COL_W'(len - 1);
    return col_pos;
  endfunction

  function automatic bit keeps_chroma();
    return (mode_reg == MODE_PROGRESSIVE) ? !row_pos[0] : !row_pos[1];
  endfunction

  function automatic logic [y2n_pkg::ADDR_W-1:0] store_addr(
    input logic [y2n_pkg::COL_W-1:0] col
  );
    return {(mode_reg == MODE_INTERLACED) & row_pos[0], col};
  endfunction

  function automatic nv12_word_t convert_macropixel(input yuy2_word_t w);
    logic [y2n_pkg::PPL_W-1:0]   len;
    logic [y2n_pkg::COL_W-1:0]   col;
    logic [y2n_pkg::ADDR_W-1:0]  addr;
    logic [y2n_pkg::STORE_W-1:0] held;
    logic [9:0]                  sum_b;
    logic [9:0]                  sum_r;
    nv12_word_t                  r;
    if (w.frame_start) begin
      col_pos = '0;
      row_pos = '0;
    end
    len = line_len();
    col = line_col(len);
    addr = store_addr(col);
    r = '0;
    r.luma_first = w.luma_first;
    r.luma_second = w.luma_second;
    r.end_of_line = (y2n_pkg::PPL_W'(col) == len - 1);
    if (keeps_chroma()) begin
      chroma_store[addr] = {w.chroma_red, w.chroma_blue};
      store_written[addr] = 1'b1;
    end else begin
      held = chroma_store[addr];
      r.chroma_valid = 1'b1;
      if (mode_reg == MODE_PROGRESSIVE) begin
        sum_b = 10'(held[7:0]) + 10'(w.chroma_blue) + 10'd1;
        sum_r = 10'(held[15:8]) + 10'(w.chroma_red) + 10'd1;
        r.chroma_blue = sum_b[8:1];
        r.chroma_red = sum_r[8:1];
      end else begin
        if (!row_pos[0]) begin
          sum_b = 10'd3 * 10'(held[7:0]) + 10'(w.chroma_blue) + 10'd2;
          sum_r = 10'd3 * 10'(held[15:8]) + 10'(w.chroma_red) + 10'd2;
        end else begin
          sum_b = 10'(held[7:0]) + 10'd3 * 10'(w.chroma_blue) + 10'd2;
          sum_r = 10'(held[15:8]) + 10'd3 * 10'(w.chroma_red) + 10'd2;
        end
        r.chroma_blue = sum_b[9:2];
        r.chroma_red = sum_r[9:2];
      end
    end
    if (r.end_of_line) begin
      col_pos = '0;
      row_pos = row_pos + 2'd1;
    end else begin
      col_pos = col + 1'b1;
    end
    return r;
  endfunction

  function automatic yuy2_word_t macropixel(input logic [7:0] ya, input logic [7:0] cb,
                                            input logic [7:0] yb, input logic [7:0] cr,
                                            input logic fs);
    return '{ya, cb, yb, cr, fs};
  endfunction

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic yuy2_word_t random_macropixel(input logic fs);
    return macropixel(pick_sample(), pick_sample(), pick_sample(), pick_sample(), fs);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on word %0d, %s: got %0d, expected %0d", words_checked, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_word(input yuy2_word_t w);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    // A line-store entry that was never written must not be read; restart the frame instead.
    if (!w.frame_start && !keeps_chroma() && !store_written[store_addr(line_col(line_len()))])
      w.frame_start = 1'b1;
    in_valid_i <= 1'b1;
    luma_first_i <= w.luma_first;
    chroma_blue_i <= w.chroma_blue;
    luma_second_i <= w.luma_second;
    chroma_red_i <= w.chroma_red;
    frame_start_i <= w.frame_start;
    nv12_due.push_back(convert_macropixel(w));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (nv12_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [y2n_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [y2n_pkg::CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == y2n_pkg::REG_MODE_ADDR) mode_reg = value[0];
    else if (addr == y2n_pkg::REG_PPL_ADDR) ppl_reg = value[y2n_pkg::PPL_W-1:0];
  endtask

  task automatic configure(input logic mode, input logic [y2n_pkg::PPL_W-1:0] ppl);
    write_reg(y2n_pkg::REG_MODE_ADDR, y2n_pkg::CFG_DATA_W'(mode));
    write_reg(y2n_pkg::REG_PPL_ADDR, y2n_pkg::CFG_DATA_W'(ppl));
  endtask

  task automatic test_progressive_rows();
    configure(MODE_PROGRESSIVE, 12'd4);
    send_word(macropixel(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1));
    send_word(macropixel(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0));
    send_word(macropixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    send_word(macropixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_word(macropixel(8'h80, 8'hFF, 8'h01, 8'h00, 1'b0));
    send_word(macropixel(8'h01, 8'h00, 8'h80, 8'hFF, 1'b0));
    send_word(macropixel(8'hFF, 8'h01, 8'h00, 8'h00, 1'b0));
    send_word(macropixel(8'h00, 8'hFF, 8'hFF, 8'hFE, 1'b0));
    wait_drained();
  endtask

  task automatic test_interlaced_fields();
    configure(MODE_INTERLACED, 12'd2);
    send_word(macropixel(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1));
    send_word(macropixel(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0));
    send_word(macropixel(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0));
    send_word(macropixel(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0));
    send_word(macropixel(8'h01, 8'h00, 8'hFE, 8'hFF, 1'b0));
    send_word(macropixel(8'hFE, 8'h01, 8'h01, 8'hFE, 1'b0));
    send_word(macropixel(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0));
    send_word(macropixel(8'hFF, 8'h00, 8'h00, 8'h01, 1'b0));
    wait_drained();
  endtask

  task automatic test_zero_length();
    int unsigned i;
    configure(MODE_INTERLACED, 12'd0);
    for (i = 0; i < 5; i++) send_word(random_macropixel(i == 0));
    wait_drained();
  endtask

  task automatic test_line_shortened();
    int unsigned i;
    configure(MODE_PROGRESSIVE, 12'd8);
    for (i = 0; i < 6; i++) send_word(random_macropixel(i == 0));
    wait_drained();
    write_reg(y2n_pkg::REG_PPL_ADDR, y2n_pkg::CFG_DATA_W'(3));
    for (i = 0; i < 4; i++) send_word(random_macropixel(1'b0));
    wait_drained();
  endtask

  task automatic test_length_above_max();
    int unsigned i;
    src_gap_max = 0;
    sink_stall_max = 0;
    configure(MODE_PROGRESSIVE, 12'hFFF);
    for (i = 0; i < 24; i++) send_word(random_macropixel(i == 0));
    wait_drained();
    configure(MODE_INTERLACED, 12'h801);
    for (i = 0; i < 24; i++) send_word(random_macropixel(i == 0));
    wait_drained();
    src_gap_max = 8;
    sink_stall_max = 8;
  endtask

  task automatic test_random_frames();
    int unsigned phase;
    int unsigned i;
    logic [y2n_pkg::PPL_W-1:0] ppl;
    for (phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 9))
        0: ppl = '0;
        1: ppl = y2n_pkg::PPL_W'($urandom_range(17, 64));
        default: ppl = y2n_pkg::PPL_W'($urandom_range(1, 16));
      endcase
      configure(1'($urandom_range(0, 1)), ppl);
      src_gap_max = (phase % 3 == 1) ? 0 : 8;
      sink_stall_max = (phase % 4 == 2) ? 0 : 8;
      for (i = 0; i < 60; i++) begin
        if (i == 0) send_word(random_macropixel(1'($urandom_range(0, 1))));
        else send_word(random_macropixel($urandom_range(0, 31) == 0));
      end
      wait_drained();
    end
  endtask

  always @(posedge clk_i) begin
    nv12_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (nv12_due.size() == 0) begin
        report_mismatch("word without expectation", 1, 0);
      end else begin
        want = nv12_due.pop_front();
        if (luma_out_first_o !== want.luma_first)
          report_mismatch("luma_out_first", int'(luma_out_first_o), int'(want.luma_first));
        if (luma_out_second_o !== want.luma_second)
          report_mismatch("luma_out_second", int'(luma_out_second_o), int'(want.luma_second));
        if (chroma_valid_o !== want.chroma_valid)
          report_mismatch("chroma_valid", int'(chroma_valid_o), int'(want.chroma_valid));
        if (chroma_blue_out_o !== want.chroma_blue)
          report_mismatch("chroma_blue_out", int'(chroma_blue_out_o), int'(want.chroma_blue));
        if (chroma_red_out_o !== want.chroma_red)
          report_mismatch("chroma_red_out", int'(chroma_red_out_o), int'(want.chroma_red));
        if (end_of_line_o !== want.end_of_line)
          report_mismatch("end_of_line", int'(end_of_line_o), int'(want.end_of_line));
      end
      words_checked++;
      sink_hold = $urandom_range(0, sink_stall_max);
    end else if (sink_hold != 0) begin
      sink_hold--;
    end
    out_ready_i <= (sink_hold == 0);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    luma_first_i <= '0;
    chroma_blue_i <= '0;
    luma_second_i <= '0;
    chroma_red_i <= '0;
    frame_start_i <= 1'b0;
    out_ready_i <= 1'b0;
    mode_reg = MODE_PROGRESSIVE;
    ppl_reg = y2n_pkg::PPL_RESET;
    col_pos = '0;
    row_pos = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_progressive_rows();
    test_interlaced_fields();
    test_zero_length();
    test_line_shortened();
    test_length_above_max();
    test_random_frames();
    wait_drained();
    if (mismatch_count == 0 && nv12_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
